>>> rtl/dpt_pkg.sv
package dpt_pkg;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned ANGLE_W    = 8;
    localparam int unsigned TARGET_W   = 7;
    localparam int unsigned REMAIN_W   = 17;
    localparam int unsigned PRODUCT_W  = TARGET_W + CFG_W;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned SPAN_W     = PRODUCT_W - FRAC_BITS;

    localparam logic [CFG_W-1:0] RESET_TIME_DEFAULT  = 16'd10000;
    localparam logic [CFG_W-1:0] SETTLE_TIME_DEFAULT = 16'd2500;
    localparam logic [CFG_W-1:0] DEGREE_TIME_DEFAULT = 16'd24178;

    localparam logic [TARGET_W-1:0] NO_ANGLE  = 7'd99;
    localparam logic [TARGET_W-1:0] MAX_ANGLE = 7'd90;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SET    = 2'd1,
        KIND_MANUAL = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MAN_OFF     = 2'd0,
        MAN_FORWARD = 2'd1,
        MAN_REVERSE = 2'd2
    } manual_t;

    typedef enum logic [2:0] {
        ST_TICK     = 3'd0,
        ST_REJECTED = 3'd1,
        ST_THERE    = 3'd2,
        ST_REVERSE  = 3'd3,
        ST_MOVING   = 3'd4,
        ST_MANUAL   = 3'd5,
        ST_READ     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_RETURN = 2'd1,
        PH_MOVE   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        REG_RESET_TIME  = 2'd0,
        REG_SETTLE_TIME = 2'd1,
        REG_DEGREE_TIME = 2'd2
    } cfg_reg_t;

endpackage

>>> rtl/damper_position_timer_unit.sv
// Damper position timer: open-loop timed drive of a two-wire damper motor.
// Input channel (in_valid / in_stall): one transaction carries kind, angle and
// manual_drive; kind is a 1 ms tick, a set-angle request, a manual drive or a
// read. Every input transaction yields exactly one result transaction on the
// output channel (out_valid / out_stall) with status, both motor line levels,
// the stored target angle and the motion phase.
// Configuration (cfg_valid / cfg_ready): cfg_ready is always high; index 0
// reset time, 1 settle time, 2 per-degree time in ms with 8 fraction bits.
// Write only while the block is idle.
// Timing: the input register loads at the accepting edge; the result register
// loads from it when the output register is empty or not stalled.
// Throughput: one transaction per cycle while out_stall is low; the update pass
// holds one 7x16 multiply and one 17-bit add, which set the cycle time.
// Reset: phase idle, target 99 (never set), countdown zero, both stored line
// levels low, configuration back to its defaults, no results pending.
// Receiver stall: the result register holds; the input register holds behind
// it and in_stall rises while it is full, so nothing is lost or repeated.
module damper_position_timer_unit
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [dpt_pkg::CFG_W-1:0]          cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic [dpt_pkg::ANGLE_W-1:0]        angle,
    input  logic [1:0]                         manual_drive,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         status,
    output logic                               forward_drive,
    output logic                               reverse_drive,
    output logic [dpt_pkg::TARGET_W-1:0]       target_angle_out,
    output logic [1:0]                         phase
);

    logic [dpt_pkg::CFG_W-1:0]      reset_time_reg;
    logic [dpt_pkg::CFG_W-1:0]      settle_time_reg;
    logic [dpt_pkg::CFG_W-1:0]      degree_time_reg;

    logic                           in_valid_reg;
    dpt_pkg::kind_t                 kind_reg;
    logic [dpt_pkg::ANGLE_W-1:0]    angle_reg;
    dpt_pkg::manual_t               manual_reg;

    dpt_pkg::phase_t                phase_reg;
    dpt_pkg::phase_t                phase_next;
    logic [dpt_pkg::TARGET_W-1:0]   target_reg;
    logic [dpt_pkg::TARGET_W-1:0]   target_next;
    logic [dpt_pkg::REMAIN_W-1:0]   remain_reg;
    logic [dpt_pkg::REMAIN_W-1:0]   remain_next;
    logic                           fwd_reg;
    logic                           fwd_next;
    logic                           rev_reg;
    logic                           rev_next;
    dpt_pkg::status_t               status_next;

    logic                           out_valid_reg;
    dpt_pkg::status_t               status_reg;
    logic                           out_fwd_reg;
    logic                           out_rev_reg;
    logic [dpt_pkg::TARGET_W-1:0]   out_target_reg;
    dpt_pkg::phase_t                out_phase_reg;

    logic                           out_open;
    logic                           in_take;
    logic                           do_step;
    logic                           angle_ok;
    logic [dpt_pkg::TARGET_W-1:0]   mult_arg;
    logic [dpt_pkg::PRODUCT_W-1:0]  product;
    logic [dpt_pkg::SPAN_W-1:0]     span;
    logic [dpt_pkg::REMAIN_W-1:0]   remain_dec;

    assign cfg_ready = 1'b1;

    assign out_open = !out_valid_reg || !out_stall;
    assign do_step  = in_valid_reg && out_open;
    assign in_stall = in_valid_reg && !out_open;
    assign in_take  = in_valid && !in_stall;

    assign angle_ok = angle_reg <= {1'b0, dpt_pkg::MAX_ANGLE};
    assign mult_arg = (kind_reg == dpt_pkg::KIND_SET)
                    ? dpt_pkg::MAX_ANGLE - angle_reg[dpt_pkg::TARGET_W-1:0]
                    : target_reg;
    assign product  = mult_arg * degree_time_reg;
    assign span     = product[dpt_pkg::PRODUCT_W-1:dpt_pkg::FRAC_BITS];
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        target_next = target_reg;
        remain_next = remain_reg;
        fwd_next    = fwd_reg;
        rev_next    = rev_reg;
        status_next = dpt_pkg::ST_READ;
        unique case (kind_reg)
            dpt_pkg::KIND_TICK:
            begin
                status_next = dpt_pkg::ST_TICK;
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    if (phase_reg == dpt_pkg::PH_RETURN)
                    begin
                        phase_next = dpt_pkg::PH_MOVE;
                        rev_next   = 1'b0;
                        if (target_reg != '0)
                        begin
                            remain_next = {1'b0, settle_time_reg}
                                        + {{(dpt_pkg::REMAIN_W-dpt_pkg::SPAN_W){1'b0}}, span};
                            fwd_next    = 1'b1;
                        end
                    end
                    else if (phase_reg == dpt_pkg::PH_MOVE)
                    begin
                        fwd_next = 1'b0;
                        rev_next = 1'b0;
                    end
                end
            end
            dpt_pkg::KIND_SET:
            begin
                fwd_next = 1'b0;
                rev_next = 1'b0;
                priority if (!angle_ok)
                begin
                    status_next = dpt_pkg::ST_REJECTED;
                end
                else if (angle_reg[dpt_pkg::TARGET_W-1:0] == target_reg)
                begin
                    status_next = dpt_pkg::ST_THERE;
                end
                else if (target_reg == dpt_pkg::MAX_ANGLE)
                begin
                    status_next = dpt_pkg::ST_REVERSE;
                    target_next = angle_reg[dpt_pkg::TARGET_W-1:0];
                    phase_next  = dpt_pkg::PH_MOVE;
                    rev_next    = 1'b1;
                    remain_next = {{(dpt_pkg::REMAIN_W-dpt_pkg::SPAN_W){1'b0}}, span};
                end
                else
                begin
                    status_next = dpt_pkg::ST_MOVING;
                    target_next = angle_reg[dpt_pkg::TARGET_W-1:0];
                    phase_next  = dpt_pkg::PH_RETURN;
                    rev_next    = 1'b1;
                    remain_next = {1'b0, reset_time_reg};
                end
            end
            dpt_pkg::KIND_MANUAL:
            begin
                status_next = dpt_pkg::ST_MANUAL;
                fwd_next    = manual_reg == dpt_pkg::MAN_FORWARD;
                rev_next    = manual_reg == dpt_pkg::MAN_REVERSE;
            end
            default:
            begin
                status_next = dpt_pkg::ST_READ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_time_reg  <= dpt_pkg::RESET_TIME_DEFAULT;
            settle_time_reg <= dpt_pkg::SETTLE_TIME_DEFAULT;
            degree_time_reg <= dpt_pkg::DEGREE_TIME_DEFAULT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dpt_pkg::REG_RESET_TIME:  reset_time_reg  <= cfg_data;
                dpt_pkg::REG_SETTLE_TIME: settle_time_reg <= cfg_data;
                dpt_pkg::REG_DEGREE_TIME: degree_time_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take || do_step)
        begin
            in_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= dpt_pkg::kind_t'(kind);
            angle_reg  <= angle;
            manual_reg <= dpt_pkg::manual_t'(manual_drive);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dpt_pkg::PH_IDLE;
            target_reg <= dpt_pkg::NO_ANGLE;
            remain_reg <= '0;
            fwd_reg    <= 1'b0;
            rev_reg    <= 1'b0;
        end
        else if (do_step)
        begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            remain_reg <= remain_next;
            fwd_reg    <= fwd_next;
            rev_reg    <= rev_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            status_reg     <= status_next;
            out_fwd_reg    <= fwd_next;
            out_rev_reg    <= rev_next;
            out_target_reg <= target_next;
            out_phase_reg  <= phase_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign forward_drive    = out_fwd_reg;
    assign reverse_drive    = out_rev_reg;
    assign target_angle_out = out_target_reg;
    assign phase            = out_phase_reg;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CFG_W     = dpt_pkg::CFG_W;
    localparam int unsigned ANGLE_W   = dpt_pkg::ANGLE_W;
    localparam int unsigned TARGET_W  = dpt_pkg::TARGET_W;
    localparam int unsigned REMAIN_W  = dpt_pkg::REMAIN_W;
    localparam int unsigned FRAC_BITS = dpt_pkg::FRAC_BITS;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0] MAN_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD = 120;
    localparam int unsigned PHASE_ITEMS = 190;

    typedef struct packed {
        dpt_pkg::kind_t     kind;
        logic [ANGLE_W-1:0] angle;
        logic [1:0]         manual;
    } damper_cmd_t;

    typedef struct packed {
        dpt_pkg::status_t    status;
        logic                fwd;
        logic                rev;
        logic [TARGET_W-1:0] target;
        dpt_pkg::phase_t     phase;
    } damper_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind = '0;
    logic [ANGLE_W-1:0] angle = '0;
    logic [1:0]         manual_drive = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic               forward_drive;
    logic               reverse_drive;
    logic [TARGET_W-1:0] target_angle_out;
    logic [1:0]         phase;

    // predicted state of the damper timer
    logic [CFG_W-1:0]    cfg_reset_time;
    logic [CFG_W-1:0]    cfg_settle_time;
    logic [CFG_W-1:0]    cfg_degree_time;
    dpt_pkg::phase_t     phase_q;
    logic [TARGET_W-1:0] target_q;
    logic [REMAIN_W-1:0] remain_q;
    logic                fwd_q;
    logic                rev_q;

    damper_cmd_t  pending_commands[$];
    damper_resp_t expected_responses[$];
    damper_cmd_t  cmd_now;
    damper_resp_t seen_resp;

    int unsigned commands_queued = 0;
    int unsigned results_checked = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned in_gap_max = 8;
    int unsigned out_wait_max = 8;
    int unsigned gap_left = 0;
    int unsigned wait_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned draw;
    logic [ANGLE_W-1:0] last_angle = '0;

    damper_position_timer_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .angle            (angle),
        .manual_drive     (manual_drive),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .forward_drive    (forward_drive),
        .reverse_drive    (reverse_drive),
        .target_angle_out (target_angle_out),
        .phase            (phase)
    );

    always #5 clk = ~clk;

    function automatic logic [REMAIN_W-1:0] degree_span(logic [TARGET_W-1:0] degrees);
        int unsigned product;
        product = 32'(degrees) * 32'(cfg_degree_time);
        return REMAIN_W'(product >> FRAC_BITS);
    endfunction

    function automatic damper_resp_t predict_damper_response(damper_cmd_t c);
        damper_resp_t r;
        r.status = dpt_pkg::ST_TICK;
        case (c.kind)
            dpt_pkg::KIND_TICK:
            begin
                if (remain_q != 0)
                    remain_q = remain_q - 1'b1;
                if (remain_q == 0)
                begin
                    if (phase_q == dpt_pkg::PH_RETURN)
                    begin
                        phase_q = dpt_pkg::PH_MOVE;
                        rev_q = 1'b0;
                        if (target_q != 0)
                        begin
                            remain_q = REMAIN_W'(32'(cfg_settle_time)
                                                 + 32'(degree_span(target_q)));
                            fwd_q = 1'b1;
                        end
                    end
                    else if (phase_q == dpt_pkg::PH_MOVE)
                    begin
                        fwd_q = 1'b0;
                        rev_q = 1'b0;
                    end
                end
                r.status = dpt_pkg::ST_TICK;
            end
            dpt_pkg::KIND_SET:
            begin
                fwd_q = 1'b0;
                rev_q = 1'b0;
                if (c.angle > ANGLE_W'(dpt_pkg::MAX_ANGLE))
                    r.status = dpt_pkg::ST_REJECTED;
                else if (c.angle == ANGLE_W'(target_q))
                    r.status = dpt_pkg::ST_THERE;
                else if (target_q == dpt_pkg::MAX_ANGLE)
                begin
                    target_q = c.angle[TARGET_W-1:0];
                    phase_q = dpt_pkg::PH_MOVE;
                    rev_q = 1'b1;
                    remain_q = degree_span(dpt_pkg::MAX_ANGLE - c.angle[TARGET_W-1:0]);
                    r.status = dpt_pkg::ST_REVERSE;
                end
                else
                begin
                    target_q = c.angle[TARGET_W-1:0];
                    phase_q = dpt_pkg::PH_RETURN;
                    rev_q = 1'b1;
                    remain_q = REMAIN_W'(cfg_reset_time);
                    r.status = dpt_pkg::ST_MOVING;
                end
            end
            dpt_pkg::KIND_MANUAL:
            begin
                fwd_q = (c.manual == dpt_pkg::MAN_FORWARD);
                rev_q = (c.manual == dpt_pkg::MAN_REVERSE);
                r.status = dpt_pkg::ST_MANUAL;
            end
            default:
                r.status = dpt_pkg::ST_READ;
        endcase
        r.fwd = fwd_q;
        r.rev = rev_q;
        r.target = target_q;
        r.phase = phase_q;
        return r;
    endfunction

    function automatic void flag_mismatch(string field, int unsigned want, logic [7:0] got);
        errors++;
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    task automatic add_command(dpt_pkg::kind_t k, logic [ANGLE_W-1:0] a, logic [1:0] m);
        damper_cmd_t c;
        c.kind = k;
        c.angle = a;
        c.manual = m;
        pending_commands.push_back(c);
        commands_queued++;
    endtask

    task automatic write_register(logic [1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            dpt_pkg::REG_RESET_TIME:  cfg_reset_time = value;
            dpt_pkg::REG_SETTLE_TIME: cfg_settle_time = value;
            dpt_pkg::REG_DEGREE_TIME: cfg_degree_time = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_W-1:0] r, logic [CFG_W-1:0] s, logic [CFG_W-1:0] d);
        write_register(dpt_pkg::REG_RESET_TIME, r);
        write_register(dpt_pkg::REG_SETTLE_TIME, s);
        write_register(dpt_pkg::REG_DEGREE_TIME, d);
    endtask

    task automatic settle_all();
        while (results_checked != commands_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return ANGLE_W'(dpt_pkg::MAX_ANGLE);
            1: return '0;
            2: return ANGLE_W'($urandom_range(91, 255));
            3: return last_angle;
            default: return ANGLE_W'($urandom_range(0, 90));
        endcase
    endfunction

    // mostly a set-angle followed by a random run of up to 300 mostly-tick commands
    task automatic queue_random_traffic(int unsigned count);
        int unsigned made;
        int unsigned reach;
        int unsigned burst;
        logic [ANGLE_W-1:0] a;
        made = 0;
        reach = cfg_reset_time + cfg_settle_time + ((90 * cfg_degree_time) >> FRAC_BITS) + 4;
        if (reach > 300)
            reach = 300;
        while (made < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                a = pick_angle();
                last_angle = a;
                add_command(dpt_pkg::KIND_SET, a, 2'($urandom));
                made++;
                burst = $urandom_range(0, reach);
                if (burst > count - made)
                    burst = count - made;
                repeat (burst)
                begin
                    case ($urandom_range(0, 19))
                        0: add_command(dpt_pkg::KIND_READ, 8'($urandom), 2'($urandom));
                        1: add_command(dpt_pkg::KIND_MANUAL, 8'($urandom), 2'($urandom));
                        default: add_command(dpt_pkg::KIND_TICK, 8'($urandom), 2'($urandom));
                    endcase
                    made++;
                end
            end
            else
            begin
                add_command(dpt_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom),
                            2'($urandom));
                made++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_responses.push_back(predict_damper_response(cmd_now));
            if (in_valid && in_stall)
            begin
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_commands.size() > 0)
            begin
                cmd_now = pending_commands.pop_front();
                kind <= cmd_now.kind;
                angle <= cmd_now.angle;
                manual_drive <= cmd_now.manual;
                in_valid <= 1'b1;
                gap_left <= $urandom_range(0, in_gap_max);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_responses.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected transaction: status %0d", $time, status);
                end
                else
                begin
                    seen_resp = expected_responses.pop_front();
                    results_checked++;
                    if (status !== seen_resp.status)
                        flag_mismatch("status", seen_resp.status, 8'(status));
                    if (forward_drive !== seen_resp.fwd)
                        flag_mismatch("forward_drive", seen_resp.fwd, 8'(forward_drive));
                    if (reverse_drive !== seen_resp.rev)
                        flag_mismatch("reverse_drive", seen_resp.rev, 8'(reverse_drive));
                    if (target_angle_out !== seen_resp.target)
                        flag_mismatch("target_angle_out", seen_resp.target,
                                      8'(target_angle_out));
                    if (phase !== seen_resp.phase)
                        flag_mismatch("phase", seen_resp.phase, 8'(phase));
                end
            end

            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left <= LONG_HOLD;
                out_stall <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                draw = $urandom_range(0, out_wait_max);
                out_stall <= (draw != 0);
                wait_left <= (draw > 0) ? draw - 1 : 0;
            end
            else if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left <= wait_left - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        cfg_reset_time = dpt_pkg::RESET_TIME_DEFAULT;
        cfg_settle_time = dpt_pkg::SETTLE_TIME_DEFAULT;
        cfg_degree_time = dpt_pkg::DEGREE_TIME_DEFAULT;
        phase_q = dpt_pkg::PH_IDLE;
        target_q = dpt_pkg::NO_ANGLE;
        remain_q = '0;
        fwd_q = 1'b0;
        rev_q = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // default timing
        add_command(dpt_pkg::KIND_READ, 8'd0, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_TICK, 8'hFF, MAN_UNUSED);
        add_command(dpt_pkg::KIND_MANUAL, 8'd0, dpt_pkg::MAN_FORWARD);
        add_command(dpt_pkg::KIND_TICK, 8'd0, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_MANUAL, 8'd0, dpt_pkg::MAN_REVERSE);
        add_command(dpt_pkg::KIND_MANUAL, 8'd0, MAN_UNUSED);
        add_command(dpt_pkg::KIND_MANUAL, 8'd0, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_SET, 8'd91, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_SET, 8'd255, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_SET, 8'd90, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_SET, 8'd90, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_TICK, 8'd0, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_SET, 8'd0, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_SET, 8'd0, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_MANUAL, 8'hFF, dpt_pkg::MAN_FORWARD);
        add_command(dpt_pkg::KIND_TICK, 8'd0, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_SET, 8'd90, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_SET, 8'd45, dpt_pkg::MAN_OFF);
        add_command(dpt_pkg::KIND_READ, 8'hFF, MAN_UNUSED);
        queue_random_traffic(100);
        settle_all();

        // unused index must leave all timing untouched
        write_register(REG_UNUSED, 16'($urandom));

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: configure(16'd2, 16'd1, 16'd256);
                1: configure(16'd0, 16'd0, 16'd0);
                2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: configure(16'd1, 16'd0, 16'hFFFF);
                4: configure(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                             16'($urandom_range(0, 600)));
                5: configure(16'd0, 16'hFFFF, 16'd1);
                default: configure(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            in_gap_max = (p % 3 == 1) ? 0 : 8;
            out_wait_max = (p % 3 == 1) ? 0 : 8;
            if (p == 0)
            begin
                // return to zero, forced-low end of move, short forward run
                add_command(dpt_pkg::KIND_SET, 8'd0, dpt_pkg::MAN_OFF);
                add_command(dpt_pkg::KIND_TICK, 8'd0, dpt_pkg::MAN_OFF);
                add_command(dpt_pkg::KIND_TICK, 8'd0, dpt_pkg::MAN_OFF);
                add_command(dpt_pkg::KIND_MANUAL, 8'd0, dpt_pkg::MAN_FORWARD);
                add_command(dpt_pkg::KIND_TICK, 8'd0, dpt_pkg::MAN_OFF);
                add_command(dpt_pkg::KIND_SET, 8'd3, dpt_pkg::MAN_OFF);
                repeat (6) add_command(dpt_pkg::KIND_TICK, 8'd0, dpt_pkg::MAN_OFF);
            end
            queue_random_traffic(PHASE_ITEMS);
            if (p == 1 || p == 4)
                hold_req++;
            settle_all();
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && expected_responses.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> damper_position_timer_unit.f
rtl/dpt_pkg.sv
rtl/damper_position_timer_unit.sv
verif/testbench.sv
